// ----- sv/sorted_priority_queue_core_assert.svh -----
// assertion macros for the sorted priority queue core
`ifndef SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define SPQ_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("spq assertion failed");
// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spq assertion failed");
`else
`define SPQ_ASSERT(label, prop)
`define SPQ_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- sv/spq_pkg.sv -----
// shared types and codes for the sorted priority queue
package spq_pkg;

	localparam logic MODE_ENQ = 1'b0;
	localparam logic MODE_DEQ = 1'b1;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd2;

	localparam int DATA_W = 32;
	localparam int PRIO_W = 16;
	localparam int CNT_OUT_W = 5;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_op;
		logic exec;
		logic load_out;
	} spq_cmd_t;

endpackage

// ----- sv/sorted_priority_queue_core.sv -----
// Sorted priority queue core: holds up to CAPACITY entries (32-bit data, 16-bit signed
// priority) in a row of slot registers ordered from the highest priority down, slot 0
// being the head. An enqueue lands behind every held entry of greater or equal
// priority, so equal priorities leave in arrival order; a dequeue pops the head.
// Every input transaction returns exactly one result transaction with a status
// (ok, underflow on an empty dequeue, overflow on a full enqueue, the item dropped),
// the empty flag, the entry count and the head entry after the operation (zero when
// empty). One item is in flight at a time and passes through capture, a parallel
// compare-and-shift over all slots, and loading the result
// register; the result register lets the next item be taken while the previous
// result still waits, and a stalled result holds the report step until it drains.
`include "sorted_priority_queue_core_assert.svh"
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // data_value[31:0], priority_req[47:32]
	input  logic        s_tuser,   // mode (0 enqueue, 1 dequeue)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // status[1:0], empty_res[2], entry_count[7:3],
	                               // head_data[39:8], head_priority[55:40]
);

	spq_cmd_t              cmd;
	logic [1:0]            res_status;
	logic                  res_empty;
	logic [CNT_OUT_W-1:0]  res_count;
	logic [DATA_W-1:0]     res_head_data;
	logic [PRIO_W-1:0]     res_head_prio;

	// sequencing: accept, update the slots, report
	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	// slot row, fill counter and result register
	spq_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.in_mode       (s_tuser),
		.in_data       (s_tdata[31:0]),
		.in_prio       (s_tdata[47:32]),
		.res_status    (res_status),
		.res_empty     (res_empty),
		.res_count     (res_count),
		.res_head_data (res_head_data),
		.res_head_prio (res_head_prio)
	);

	// result transaction packing, highest field first
	assign m_tdata = {res_head_prio, res_head_data, res_count, res_empty, res_status};

	// only one item in flight: an accepted transaction closes the input side
	`SPQ_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
	// controller issues at most one command per cycle
	`SPQ_ASSERT(a_cmd_onehot, $onehot0(cmd))
	// the slot update always follows a capture
	`SPQ_ASSERT(a_exec_after_load, cmd.exec |-> $past(cmd.load_op))
	// a loaded result is presented on the output side
	`SPQ_ASSERT_NEXT(a_load_shows_result, cmd.load_out, m_tvalid)

endmodule

// ----- sv/spq_ctrl.sv -----
// controller state machine for the sorted priority queue
module spq_ctrl import spq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	output spq_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_EXEC   = 3'b010,
		ST_REPORT = 3'b100
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_op = 1'b1;
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_nxt = ST_REPORT;
			end
			ST_REPORT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/spq_datapath.sv -----
// slot row, occupancy counter and result register of the sorted priority queue
module spq_datapath import spq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  spq_cmd_t                 cmd,
	input  logic                     in_mode,
	input  logic [DATA_W-1:0]        in_data,
	input  logic [PRIO_W-1:0]        in_prio,
	output logic [1:0]               res_status,
	output logic                     res_empty,
	output logic [CNT_OUT_W-1:0]     res_count,
	output logic [DATA_W-1:0]        res_head_data,
	output logic [PRIO_W-1:0]        res_head_prio
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

	logic              op_mode_q;
	logic [DATA_W-1:0] op_data_q;
	logic [PRIO_W-1:0] op_prio_q;
	logic [1:0]        status_q;
	logic [CNT_W-1:0]  count_q;

	logic [DATA_W-1:0] slot_data_q [CAPACITY];
	logic [PRIO_W-1:0] slot_prio_q [CAPACITY];

	logic [CAPACITY-1:0] keep;
	logic [CAPACITY-1:0] keep_prev;
	logic                full;
	logic                empty;
	logic                do_enq;
	logic                do_deq;
	logic [EXT_W-1:0]    count_ext;

	assign full   = (count_q == CNT_W'(CAPACITY));
	assign empty  = (count_q == '0);
	assign do_enq = cmd.exec && (op_mode_q == MODE_ENQ) && !full;
	assign do_deq = cmd.exec && (op_mode_q == MODE_DEQ) && !empty;
	assign keep_prev = {keep[CAPACITY-2:0], 1'b1};
	assign count_ext = EXT_W'(count_q);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
		localparam logic [CNT_W-1:0] SLOT_IDX = CNT_W'(i);
		logic [DATA_W-1:0] up_data;
		logic [PRIO_W-1:0] up_prio;
		logic [DATA_W-1:0] down_data;
		logic [PRIO_W-1:0] down_prio;

		// held entry stays in place when it ranks at or above the new one
		assign keep[i] = (SLOT_IDX < count_q) &&
			($signed(slot_prio_q[i]) >= $signed(op_prio_q));

		if (i == 0) begin : g_first
			assign up_data = op_data_q;
			assign up_prio = op_prio_q;
		end else begin : g_up
			assign up_data = slot_data_q[i-1];
			assign up_prio = slot_prio_q[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign down_data = slot_data_q[i];
			assign down_prio = slot_prio_q[i];
		end else begin : g_down
			assign down_data = slot_data_q[i+1];
			assign down_prio = slot_prio_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (do_enq) begin
				if (!keep[i]) begin
					slot_data_q[i] <= keep_prev[i] ? op_data_q : up_data;
					slot_prio_q[i] <= keep_prev[i] ? op_prio_q : up_prio;
				end
			end else if (do_deq) begin
				slot_data_q[i] <= down_data;
				slot_prio_q[i] <= down_prio;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_enq) begin
			count_q <= count_q + CNT_W'(1);
		end else if (do_deq) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_mode_q <= in_mode;
			op_data_q <= in_data;
			op_prio_q <= in_prio;
		end
		if (cmd.exec) begin
			priority if ((op_mode_q == MODE_ENQ) && full) begin
				status_q <= STAT_OVERFLOW;
			end else if ((op_mode_q == MODE_DEQ) && empty) begin
				status_q <= STAT_UNDERFLOW;
			end else begin
				status_q <= STAT_OK;
			end
		end
		if (cmd.load_out) begin
			res_status    <= status_q;
			res_empty     <= empty;
			res_count     <= count_ext[CNT_OUT_W-1:0];
			res_head_data <= empty ? '0 : slot_data_q[0];
			res_head_prio <= empty ? '0 : slot_prio_q[0];
		end
	end

endmodule
